[hw/rtl/mouse_packet_cursor_tracker_top_assert.svh]
// ----------------------------------------------------------------------------
// Mouse packet cursor tracker assertion macros
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef MOUSE_PACKET_CURSOR_TRACKER_TOP_ASSERT_SVH
`define MOUSE_PACKET_CURSOR_TRACKER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define MPCT_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mpct assertion failed");

`define MPCT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mpct assertion failed");

`else

`define MPCT_ASSERT_IMPL(lbl, ante, cons)
`define MPCT_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[hw/rtl/mpct_pkg.sv]
// ----------------------------------------------------------------------------
// mpct_pkg
// Shared types and constants of the mouse packet cursor tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package mpct_pkg;

	localparam int unsigned REG_W   = 12;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned DELTA_W = 9;
	localparam int unsigned POS_W   = 12;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned OUT_TDATA_W = 48;

	localparam logic [REG_W-1:0] SCREEN_WIDTH_RST  = 12'd1024;
	localparam logic [REG_W-1:0] SCREEN_HEIGHT_RST = 12'd768;
	localparam logic [REG_W-1:0] CURSOR_WIDTH_RST  = 12'd16;
	localparam logic [REG_W-1:0] CURSOR_HEIGHT_RST = 12'd16;

	localparam int unsigned SYNC_BIT    = 3;
	localparam int unsigned X_SIGN_BIT  = 4;
	localparam int unsigned Y_SIGN_BIT  = 5;
	localparam int unsigned LEFT_BIT    = 0;
	localparam int unsigned RIGHT_BIT   = 1;
	localparam int unsigned MIDDLE_BIT  = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SCREEN_WIDTH  = 2'd0,
		CFG_SCREEN_HEIGHT = 2'd1,
		CFG_CURSOR_WIDTH  = 2'd2,
		CFG_CURSOR_HEIGHT = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		IDX_STATUS = 2'd0,
		IDX_XDATA  = 2'd1,
		IDX_YDATA  = 2'd2
	} idx_t;

	typedef struct packed {
		logic [REG_W-1:0] screen_width;
		logic [REG_W-1:0] screen_height;
		logic [REG_W-1:0] cursor_width;
		logic [REG_W-1:0] cursor_height;
	} cfg_t;

	typedef struct packed {
		logic               last;
		logic [DELTA_W-1:0] dx;
		logic [DELTA_W-1:0] dy;
		logic               left;
		logic               middle;
		logic               right;
	} pkt_t;

endpackage

`default_nettype wire

[hw/rtl/mouse_packet_cursor_tracker_top.sv]
// ----------------------------------------------------------------------------
// mouse_packet_cursor_tracker_top
// PS/2 mouse packet decoder with cursor tracking.
// ----------------------------------------------------------------------------
// Takes one mouse byte per cycle and emits one transaction per completed
// 3-byte packet: deltas, cursor position and buttons. A byte is registered
// on entry, decoded and checked against the screen bounds in the next cycle,
// and the result of a completed packet then lands in the output register,
// which drives the output transaction until it is accepted. Status and X bytes
// always move on at once, so bytes are taken back to back; only a third byte
// waits, holding the input, while the previous result is still unaccepted.
// ----------------------------------------------------------------------------
`default_nettype none

`include "mouse_packet_cursor_tracker_top_assert.svh"

module mouse_packet_cursor_tracker_top (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// [7:0] mouse_byte
	input  wire logic [mpct_pkg::BYTE_W-1:0]      s_tdata,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// [8:0] delta_x, [17:9] delta_y, [29:18] cursor_x, [41:30] cursor_y,
	// [42] left_button, [43] middle_button, [44] right_button, [47:45] zero
	output logic [mpct_pkg::OUT_TDATA_W-1:0]      m_tdata,
	input  wire logic                             cfg_wen,
	input  wire logic [mpct_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [mpct_pkg::REG_W-1:0]       cfg_data
);
	import mpct_pkg::*;

	cfg_t              cfg;
	pkt_t              pkt;
	idx_t              idx;
	logic              s1_valid_q;
	logic [BYTE_W-1:0] byte_s1;
	logic              advance;
	logic              push;
	logic [POS_W-1:0]  cur_x;
	logic [POS_W-1:0]  cur_y;
	logic              out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	mpct_config u_config (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mpct_packer u_packer (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.mouse_byte (byte_s1),
		.pkt        (pkt),
		.idx        (idx)
	);

	mpct_cursor u_cursor (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.commit (push),
		.dx     (pkt.dx),
		.dy     (pkt.dy),
		.cur_x  (cur_x),
		.cur_y  (cur_y)
	);

	assign advance  = s1_valid_q && (!pkt.last || !out_valid_q || m_tready);
	assign push     = advance && pkt.last;
	assign s_tready = !s1_valid_q || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_data_q <= {3'b000, pkt.right, pkt.middle, pkt.left,
				cur_y, cur_x, pkt.dy, pkt.dx};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	`MPCT_ASSERT_IMPL(a_push_on_third_byte, push, s1_valid_q && idx == IDX_YDATA)
	`MPCT_ASSERT_IMPL(a_push_needs_room, push && out_valid_q, m_tready)
	`MPCT_ASSERT_IMPL(a_stall_means_held, !s_tready, s1_valid_q && !advance)
	`MPCT_ASSERT_NEXT(a_held_byte_stable, s1_valid_q && !advance, s1_valid_q && $stable(byte_s1))

endmodule

`default_nettype wire

[hw/rtl/mpct_config.sv]
// ----------------------------------------------------------------------------
// mpct_config
// Screen and cursor size registers written through the configuration port.
// ----------------------------------------------------------------------------
`default_nettype none

module mpct_config (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_wen,
	input  wire logic [mpct_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [mpct_pkg::REG_W-1:0]     cfg_data,
	output mpct_pkg::cfg_t                      cfg
);
	import mpct_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_width  <= SCREEN_WIDTH_RST;
			cfg_q.screen_height <= SCREEN_HEIGHT_RST;
			cfg_q.cursor_width  <= CURSOR_WIDTH_RST;
			cfg_q.cursor_height <= CURSOR_HEIGHT_RST;
		end else if (cfg_wen) begin
			case (cfg_idx_t'(cfg_index))
				CFG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_data;
				CFG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data;
				CFG_CURSOR_WIDTH:  cfg_q.cursor_width  <= cfg_data;
				CFG_CURSOR_HEIGHT: cfg_q.cursor_height <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

[hw/rtl/mpct_packer.sv]
// ----------------------------------------------------------------------------
// mpct_packer
// Gathers status, X and Y bytes into one packet; drops unsynced first bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module mpct_packer (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        advance,
	input  wire logic [mpct_pkg::BYTE_W-1:0] mouse_byte,
	output mpct_pkg::pkt_t                   pkt,
	output mpct_pkg::idx_t                   idx
);
	import mpct_pkg::*;

	idx_t              idx_q;
	idx_t              idx_next;
	logic [BYTE_W-1:0] status_q;
	logic [BYTE_W-1:0] x_q;

	always_comb begin
		case (idx_q)
			IDX_STATUS: idx_next = mouse_byte[SYNC_BIT] ? IDX_XDATA : IDX_STATUS;
			IDX_XDATA:  idx_next = IDX_YDATA;
			IDX_YDATA:  idx_next = IDX_STATUS;
			default:    idx_next = mouse_byte[SYNC_BIT] ? IDX_XDATA : IDX_STATUS;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= IDX_STATUS;
			status_q <= '0;
			x_q      <= '0;
		end else if (advance) begin
			idx_q <= idx_next;
			if (idx_q == IDX_XDATA) begin
				x_q <= mouse_byte;
			end else if (idx_q != IDX_YDATA && mouse_byte[SYNC_BIT]) begin
				status_q <= mouse_byte;
			end
		end
	end

	always_comb begin
		pkt.last   = (idx_q == IDX_YDATA);
		pkt.dx     = {status_q[X_SIGN_BIT], x_q};
		pkt.dy     = {status_q[Y_SIGN_BIT], mouse_byte};
		pkt.left   = status_q[LEFT_BIT];
		pkt.middle = status_q[MIDDLE_BIT];
		pkt.right  = status_q[RIGHT_BIT];
	end

	assign idx = idx_q;

endmodule

`default_nettype wire

[hw/rtl/mpct_cursor.sv]
// ----------------------------------------------------------------------------
// mpct_cursor
// Cursor position register with the screen bounds test for each move.
// ----------------------------------------------------------------------------
`default_nettype none

module mpct_cursor (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire mpct_pkg::cfg_t               cfg,
	input  wire logic                         commit,
	input  wire logic [mpct_pkg::DELTA_W-1:0] dx,
	input  wire logic [mpct_pkg::DELTA_W-1:0] dy,
	output logic      [mpct_pkg::POS_W-1:0]   cur_x,
	output logic      [mpct_pkg::POS_W-1:0]   cur_y
);
	import mpct_pkg::*;

	localparam int unsigned CALC_W = POS_W + 3;

	logic [POS_W-1:0]         pos_x_q;
	logic [POS_W-1:0]         pos_y_q;
	logic signed [CALC_W-1:0] nx;
	logic signed [CALC_W-1:0] ny;
	logic signed [CALC_W-1:0] nx_far;
	logic signed [CALC_W-1:0] ny_far;
	logic                     move_ok;

	always_comb begin
		nx     = $signed({3'b000, pos_x_q}) + $signed({{(CALC_W-DELTA_W){dx[DELTA_W-1]}}, dx});
		ny     = $signed({3'b000, pos_y_q}) - $signed({{(CALC_W-DELTA_W){dy[DELTA_W-1]}}, dy});
		nx_far = nx + $signed({3'b000, cfg.cursor_width});
		ny_far = ny + $signed({3'b000, cfg.cursor_height});
		move_ok = (nx > 0) && (nx_far < $signed({3'b000, cfg.screen_width}))
			&& (ny > 0) && (ny_far < $signed({3'b000, cfg.screen_height}));
		cur_x = move_ok ? nx[POS_W-1:0] : pos_x_q;
		cur_y = move_ok ? ny[POS_W-1:0] : pos_y_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
		end else if (commit) begin
			pos_x_q <= cur_x;
			pos_y_q <= cur_y;
		end
	end

endmodule

`default_nettype wire
